@@ hw/rtl/hbpq_pkg.sv @@
// Shared types, codes and the helper function of the binary heap priority queue.
`default_nettype none

package hbpq_pkg;

  localparam int KEY_W       = 32;
  localparam int LIMIT_W     = 7;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic ORDER_MIN = 1'b0;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd3;

  localparam logic [CFG_INDEX_W-1:0] REG_HEAP_ORDER     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAPACITY_LIMIT = 2'd1;

  typedef struct packed {
    logic               heap_order;
    logic [LIMIT_W-1:0] capacity_limit;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_UP,
    S_FILL,
    S_DOWN,
    S_DONE
  } state_t;

  // True when key a belongs strictly nearer the root than key b.
  function automatic logic better(input logic signed [KEY_W-1:0] a,
                                  input logic signed [KEY_W-1:0] b,
                                  input logic                    order);
    if (order == ORDER_MIN) begin
      return a < b;
    end else begin
      return a > b;
    end
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/hbpq_ifs.sv @@
// Channel interfaces for commands, responses and configuration writes.
`default_nettype none

interface hbpq_cmd_if import hbpq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, output command, output key_value, input ready);
  modport sink   (input valid, input command, input key_value, output ready);
endinterface

interface hbpq_rsp_if import hbpq_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [KEY_W-1:0] removed_key;
  logic [COUNT_W-1:0]      entry_count;

  modport source (output valid, output status, output removed_key, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input removed_key, input entry_count,
                  output ready);
endinterface

interface hbpq_cfg_if import hbpq_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/binary_heap_priority_queue.sv @@
// Top level of the binary heap priority queue.
//
//   Channel  Direction  Payload                                  Transaction
//   cmd      in         command, key_value                       one insert or remove
//   rsp      out        status, removed_key, entry_count         one result per command
//   cfg      in         index, data                              one register write
//
// An insert into a non-empty heap sifts the new key up, and a remove that leaves entries
// sifts the last key down from the root, through at most the heap depth in levels (six for
// 64 entries); each level costs one read and write of the heap memory, whose two read
// ports fetch both children at once.
// Reset empties the heap, selects min order and sets the limit to 64; memory is stale.
// A result waits in the output register while the next command is taken; the
// sequencer stalls only when it finishes a command while that register is still full.
`default_nettype none

module binary_heap_priority_queue import hbpq_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input wire logic   clk,
  input wire logic   rst,
  hbpq_cmd_if.sink   cmd,
  hbpq_rsp_if.source rsp,
  hbpq_cfg_if.sink   cfg
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  cfg_t                    regs;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic signed [KEY_W-1:0] mem_wdata;
  logic [IDX_W-1:0]        mem_raddr_a;
  logic [IDX_W-1:0]        mem_raddr_b;
  logic signed [KEY_W-1:0] mem_rdata_a;
  logic signed [KEY_W-1:0] mem_rdata_b;

  hbpq_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hbpq_ram #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W),
    .DATA_W (KEY_W)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  hbpq_ctrl #(
    .CAPACITY (CAPACITY),
    .IDX_W    (IDX_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .cmd         (cmd),
    .rsp         (rsp),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr_a (mem_raddr_a),
    .mem_raddr_b (mem_raddr_b),
    .mem_rdata_a (mem_rdata_a),
    .mem_rdata_b (mem_rdata_b)
  );

endmodule

`default_nettype wire

@@ hw/rtl/hbpq_ram.sv @@
// Heap storage: one write port and two registered read ports.
`default_nettype none

module hbpq_ram #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [ADDR_W-1:0]        waddr,
  input  wire logic signed [DATA_W-1:0] wdata,
  input  wire logic [ADDR_W-1:0]        raddr_a,
  input  wire logic [ADDR_W-1:0]        raddr_b,
  output      logic signed [DATA_W-1:0] rdata_a,
  output      logic signed [DATA_W-1:0] rdata_b
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

@@ hw/rtl/hbpq_cfg.sv @@
// Configuration registers for heap order and capacity limit.
`default_nettype none

module hbpq_cfg import hbpq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  hbpq_cfg_if.sink  cfg,
  output cfg_t      regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.heap_order     <= ORDER_MIN;
      regs.capacity_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HEAP_ORDER:     regs.heap_order     <= cfg.data[0];
        REG_CAPACITY_LIMIT: regs.capacity_limit <= cfg.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/hbpq_ctrl.sv @@
// Command sequencer: sift-up and sift-down over the heap memory, and the result register.
`default_nettype none

module hbpq_ctrl import hbpq_pkg::*; #(
  parameter int CAPACITY = 64,
  parameter int IDX_W    = 6,
  parameter int CNT_W    = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    regs,
  hbpq_cmd_if.sink                     cmd,
  hbpq_rsp_if.source                   rsp,
  output      logic                    mem_we,
  output      logic [IDX_W-1:0]        mem_waddr,
  output      logic signed [KEY_W-1:0] mem_wdata,
  output      logic [IDX_W-1:0]        mem_raddr_a,
  output      logic [IDX_W-1:0]        mem_raddr_b,
  input  wire logic signed [KEY_W-1:0] mem_rdata_a,
  input  wire logic signed [KEY_W-1:0] mem_rdata_b
);

  localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
  localparam int CH_W  = IDX_W + 2;

  state_t                  state, state_next;
  logic [CNT_W-1:0]        count, count_next;
  logic [IDX_W-1:0]        pos, pos_next;
  logic signed [KEY_W-1:0] key, key_next;
  logic [STATUS_W-1:0]     status_q, status_q_next;
  logic signed [KEY_W-1:0] removed_q, removed_q_next;
  logic                    out_valid, out_valid_next;
  logic [STATUS_W-1:0]     out_status, out_status_next;
  logic signed [KEY_W-1:0] out_removed, out_removed_next;
  logic [COUNT_W-1:0]      out_count, out_count_next;

  logic [LIM_W-1:0] lim_ext, cap_ext, lim_eff;
  logic             full;
  logic [IDX_W-1:0] up_idx, up_up_idx;
  logic [CH_W-1:0]  l_idx, r_idx, cnt_ext;
  logic             l_ok, r_ok, take_l, take_r;
  logic signed [KEY_W-1:0] l_best_val;
  logic [IDX_W-1:0] child;
  logic [IDX_W:0]   child_l, child_r;

  assign lim_ext = LIM_W'(regs.capacity_limit);
  assign cap_ext = LIM_W'(CAPACITY);
  assign lim_eff = (lim_ext < cap_ext) ? lim_ext : cap_ext;
  assign full    = LIM_W'(count) >= lim_eff;

  assign up_idx    = IDX_W'((pos - 1'b1) >> 1);
  assign up_up_idx = IDX_W'((up_idx - 1'b1) >> 1);

  assign l_idx      = {1'b0, pos, 1'b1};
  assign r_idx      = l_idx + 1'b1;
  assign cnt_ext    = CH_W'(count);
  assign l_ok       = l_idx < cnt_ext;
  assign r_ok       = r_idx < cnt_ext;
  assign take_l     = l_ok && better(mem_rdata_a, key, regs.heap_order);
  assign l_best_val = take_l ? mem_rdata_a : key;
  assign take_r     = r_ok && better(mem_rdata_b, l_best_val, regs.heap_order);
  assign child      = take_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
  assign child_l    = {child, 1'b1};
  assign child_r    = child_l + 1'b1;

  assign cmd.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.removed_key = out_removed;
  assign rsp.entry_count = out_count;

  always_comb begin
    state_next       = state;
    count_next       = count;
    pos_next         = pos;
    key_next         = key;
    status_q_next    = status_q;
    removed_q_next   = removed_q;
    out_valid_next   = out_valid;
    out_status_next  = out_status;
    out_removed_next = out_removed;
    out_count_next   = out_count;
    mem_we           = 1'b0;
    mem_waddr        = pos;
    mem_wdata        = key;
    mem_raddr_a      = '0;
    mem_raddr_b      = '0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          removed_q_next = '0;
          if (cmd.command == CMD_INSERT) begin
            if (full) begin
              status_q_next = ST_OVERFLOW;
              state_next    = S_DONE;
            end else begin
              status_q_next = ST_INSERTED;
              key_next      = cmd.key_value;
              pos_next      = IDX_W'(count);
              count_next    = count + 1'b1;
              if (count == '0) begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = cmd.key_value;
                state_next = S_DONE;
              end else begin
                mem_raddr_a = IDX_W'((count - 1'b1) >> 1);
                state_next  = S_UP;
              end
            end
          end else begin
            if (count == '0) begin
              status_q_next = ST_UNDERFLOW;
              state_next    = S_DONE;
            end else begin
              status_q_next = ST_REMOVED;
              mem_raddr_a   = '0;
              mem_raddr_b   = IDX_W'(count - 1'b1);
              count_next    = count - 1'b1;
              state_next    = S_ROOT;
            end
          end
        end
      end
      S_ROOT: begin
        removed_q_next = mem_rdata_a;
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          key_next    = mem_rdata_b;
          pos_next    = '0;
          mem_raddr_a = IDX_W'(1);
          mem_raddr_b = IDX_W'(2);
          state_next  = S_DOWN;
        end
      end
      S_UP: begin
        mem_we = 1'b1;
        if (better(key, mem_rdata_a, regs.heap_order)) begin
          mem_wdata = mem_rdata_a;
          pos_next  = up_idx;
          if (up_idx == '0) begin
            state_next = S_FILL;
          end else begin
            mem_raddr_a = up_up_idx;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_FILL: begin
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DOWN: begin
        mem_we = 1'b1;
        if (take_l || take_r) begin
          mem_wdata   = take_r ? mem_rdata_b : mem_rdata_a;
          pos_next    = child;
          mem_raddr_a = child_l[IDX_W-1:0];
          mem_raddr_b = child_r[IDX_W-1:0];
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next   = 1'b1;
          out_status_next  = status_q;
          out_removed_next = removed_q;
          out_count_next   = COUNT_W'(count);
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pos         <= pos_next;
    key         <= key_next;
    status_q    <= status_q_next;
    removed_q   <= removed_q_next;
    out_status  <= out_status_next;
    out_removed <= out_removed_next;
    out_count   <= out_count_next;
  end

endmodule

`default_nettype wire

@@ hw/rtl/hbpq_checker.sv @@
// Port-level assertions for the binary heap priority queue, bound to the top level.
`default_nettype none

module hbpq_checker import hbpq_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    cmd_valid,
  input wire logic                    cmd_ready,
  input wire logic                    rsp_valid,
  input wire logic                    rsp_ready,
  input wire logic [STATUS_W-1:0]     rsp_status,
  input wire logic signed [KEY_W-1:0] rsp_removed_key,
  input wire logic [COUNT_W-1:0]      rsp_entry_count
);

  a_one_command_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("Command accepted while the previous one is still in work.");

  a_underflow_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ST_UNDERFLOW |-> rsp_entry_count == '0)
    else $error("Underflow reported with a nonzero entry count.");

  a_removed_key_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_REMOVED |-> rsp_removed_key == '0)
    else $error("Removed key is nonzero on a result that removed nothing.");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_removed_key) && $stable(rsp_entry_count))
    else $error("Response changed while stalled.");

endmodule

bind binary_heap_priority_queue hbpq_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_removed_key (rsp.removed_key),
  .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire
